// File: rtl/sfcd_pkg.sv
// Package for the framed channel deframer: sizes, sync codes, FSM state
// encoding and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package sfcd_pkg;

  localparam int CHANNELS_PER_PHASE = 16;
  localparam int TOTAL_CH           = 2 * CHANNELS_PER_PHASE;
  localparam int BANKS              = 3;
  localparam int MEM_DEPTH          = BANKS * CHANNELS_PER_PHASE;
  localparam int MEM_AW             = $clog2(MEM_DEPTH);
  localparam int IDX_W              = (CHANNELS_PER_PHASE > 1) ? $clog2(CHANNELS_PER_PHASE) : 1;
  localparam int K_W                = $clog2(TOTAL_CH);
  localparam int BANK_W             = 2;

  localparam int BYTE_W  = 8;
  localparam int CIDX_W  = 5;
  localparam int VALUE_W = 16;

  localparam logic [BYTE_W-1:0] VALID_LEN  = BYTE_W'((2 * CHANNELS_PER_PHASE + 1) % 256);
  localparam logic [BYTE_W-1:0] SYNC_A     = 8'hA3;
  localparam logic [BYTE_W-1:0] SYNC_B     = 8'hA4;
  localparam logic [BYTE_W-1:0] SYNC_C     = 8'hA5;
  localparam logic [BYTE_W-1:0] PHASE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] PHASE_ONE  = 8'h01;

  localparam logic [K_W-1:0]    LAST_K   = K_W'(TOTAL_CH - 1);
  localparam logic [K_W-1:0]    SPLIT_K  = K_W'(CHANNELS_PER_PHASE);
  localparam logic [CIDX_W-1:0] LAST_CIDX = CIDX_W'(TOTAL_CH - 1);

  localparam logic [BANK_W-1:0] BANK_0 = 2'd0;
  localparam logic [BANK_W-1:0] BANK_1 = 2'd1;
  localparam logic [BANK_W-1:0] BANK_2 = 2'd2;

  typedef enum logic [7:0] {
    ST_HUNT    = 8'b0000_0001,
    ST_GOT1    = 8'b0000_0010,
    ST_GOT2    = 8'b0000_0100,
    ST_PHASE   = 8'b0000_1000,
    ST_LEN     = 8'b0001_0000,
    ST_BODY    = 8'b0010_0000,
    ST_EMIT_RD = 8'b0100_0000,
    ST_EMIT_WR = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic load_phase;
    logic load_len;
    logic body_byte;
    logic commit;
    logic emit_start;
    logic emit_read;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic is_sync_a;
    logic is_sync_b;
    logic is_sync_c;
    logic len_zero;
    logic body_last;
    logic commit_ok;
    logic both_after;
    logic emit_last;
    logic out_free;
  } status_t;

  function automatic logic [MEM_AW-1:0] mem_addr(logic [BANK_W-1:0] bank,
                                                 logic [IDX_W-1:0] idx);
    return MEM_AW'(32'(bank) * CHANNELS_PER_PHASE + 32'(idx));
  endfunction

endpackage

// File: rtl/sfcd_if.sv
// Handshake channel interfaces: received bytes in, channel items out.
// Depends on sfcd_pkg.
`timescale 1ns / 1ps

interface sfcd_byte_if;
  logic                          valid;
  logic                          ready;
  logic [sfcd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcd_chan_if;
  logic                                valid;
  logic                                ready;
  logic [sfcd_pkg::CIDX_W-1:0]         channel_index;
  logic signed [sfcd_pkg::VALUE_W-1:0] channel_value;
  logic                                frame_last;

  modport source (output valid, output channel_index, output channel_value,
                  output frame_last, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input frame_last, output ready);
endinterface

// File: rtl/sync_framed_channel_deframer_unit.sv
// Top level of the framed channel deframer: controller plus datapath.
// Depends on sfcd_pkg, sfcd_if, sfcd_ctrl, sfcd_dpath.
//
//   port  dir  item                        payload
//   rx    in   one received byte           rx_byte[7:0]
//   ch    out  one channel of a frame      channel_index[4:0], channel_value[15:0], frame_last
//
// One byte is taken per cycle while parsing. A completed frame is read from the
// channel memory one channel at a time (registered read, then output load), all
// 32 items; rx is held off meanwhile. A downstream stall stretches emission;
// the last item may still wait while rx resumes. Reset is synchronous; the
// channel memory needs no clearing pass.
`timescale 1ns / 1ps

module sync_framed_channel_deframer_unit (
  input  logic             clk,
  input  logic             rst,
  sfcd_byte_if.sink        rx,
  sfcd_chan_if.source      ch
);
  import sfcd_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    rx_ready;

  assign rx.ready = rx_ready;

  sfcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfcd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx.rx_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (ch.valid),
    .out_ready (ch.ready),
    .out_index (ch.channel_index),
    .out_value (ch.channel_value),
    .out_last  (ch.frame_last)
  );

endmodule

// File: rtl/sfcd_ctrl.sv
// Parse and emit controller: sync hunt, header, body and frame emission.
// Depends on sfcd_pkg; drives commands to sfcd_dpath.
`timescale 1ns / 1ps

module sfcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_ready,
  input  sfcd_pkg::status_t sts,
  output sfcd_pkg::cmd_t    cmd
);
  import sfcd_pkg::*;

  state_t state, state_next;
  logic   fire;

  assign rx_ready = (state != ST_EMIT_RD) && (state != ST_EMIT_WR);
  assign fire     = rx_valid && rx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_HUNT, ST_GOT1, ST_GOT2: begin
        if (fire) begin
          // a fresh A3 restarts the match from its first byte
          if (state == ST_GOT2 && sts.is_sync_c) state_next = ST_PHASE;
          else if (sts.is_sync_a)                state_next = ST_GOT1;
          else if (state == ST_GOT1 && sts.is_sync_b) state_next = ST_GOT2;
          else                                   state_next = ST_HUNT;
        end
      end
      ST_PHASE: begin
        if (fire) begin
          cmd.load_phase = 1'b1;
          state_next     = ST_LEN;
        end
      end
      ST_LEN: begin
        if (fire) begin
          cmd.load_len = 1'b1;
          state_next   = sts.len_zero ? ST_HUNT : ST_BODY;
        end
      end
      ST_BODY: begin
        if (fire) begin
          cmd.body_byte = 1'b1;
          if (sts.body_last) begin
            cmd.commit = sts.commit_ok;
            if (sts.commit_ok && sts.both_after) begin
              cmd.emit_start = 1'b1;
              state_next     = ST_EMIT_RD;
            end else begin
              state_next = ST_HUNT;
            end
          end
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_read = 1'b1;
        state_next    = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_next    = sts.emit_last ? ST_HUNT : ST_EMIT_RD;
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

endmodule

// File: rtl/sfcd_dpath.sv
// Datapath: header/checksum registers, banked channel memory with bank
// pointers for staging and the two held phases, and the output register.
// Depends on sfcd_pkg; driven by sfcd_ctrl commands.
`timescale 1ns / 1ps

module sfcd_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sfcd_pkg::BYTE_W-1:0]         rx_byte,
  input  sfcd_pkg::cmd_t                      cmd,
  output sfcd_pkg::status_t                   sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sfcd_pkg::CIDX_W-1:0]         out_index,
  output logic signed [sfcd_pkg::VALUE_W-1:0] out_value,
  output logic                                out_last
);
  import sfcd_pkg::*;

  logic [BYTE_W-1:0]  packet_phase;
  logic [BYTE_W-1:0]  len_byte;
  logic [BYTE_W-1:0]  bytes_remaining;
  logic [BYTE_W-1:0]  running_xor;
  logic [BYTE_W-1:0]  low_byte_hold;
  logic               phase_zero_held;
  logic               phase_one_held;
  logic [BANK_W-1:0]  stage_bank;
  logic [BANK_W-1:0]  p0_bank;
  logic [BANK_W-1:0]  p1_bank;
  logic [K_W-1:0]     emit_k;
  logic [VALUE_W-1:0] rdata;

  logic [VALUE_W-1:0] mem [MEM_DEPTH];

  logic [BYTE_W-1:0]  pos;
  logic               good_len;
  logic               mem_we;
  logic [MEM_AW-1:0]  wr_addr;
  logic [MEM_AW-1:0]  rd_addr;
  logic               k_low;

  assign pos      = len_byte - bytes_remaining;
  assign good_len = (len_byte == VALID_LEN);
  assign mem_we   = cmd.body_byte && !sts.body_last && good_len && pos[0];
  assign wr_addr  = mem_addr(stage_bank, IDX_W'(pos[BYTE_W-1:1]));
  assign k_low    = (emit_k < SPLIT_K);
  assign rd_addr  = k_low ? mem_addr(p0_bank, IDX_W'(emit_k))
                          : mem_addr(p1_bank, IDX_W'(emit_k - SPLIT_K));

  always_comb begin
    sts.is_sync_a  = (rx_byte == SYNC_A);
    sts.is_sync_b  = (rx_byte == SYNC_B);
    sts.is_sync_c  = (rx_byte == SYNC_C);
    sts.len_zero   = (rx_byte == '0);
    sts.body_last  = (bytes_remaining <= BYTE_W'(1));
    sts.commit_ok  = good_len && (running_xor == rx_byte) &&
                     ((packet_phase == PHASE_ZERO) || (packet_phase == PHASE_ONE));
    sts.both_after = (packet_phase == PHASE_ZERO) ? phase_one_held : phase_zero_held;
    sts.emit_last  = (emit_k == LAST_K);
    sts.out_free   = !out_valid || out_ready;
  end

  // channel memory: one write port for staging, one registered read for emission
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {rx_byte, low_byte_hold};
    end
    if (cmd.emit_read) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_phase) begin
      packet_phase <= rx_byte;
      running_xor  <= rx_byte;
    end
    if (cmd.load_len) begin
      len_byte        <= rx_byte;
      bytes_remaining <= rx_byte;
      running_xor     <= running_xor ^ rx_byte;
    end
    if (cmd.body_byte) begin
      if (sts.body_last) begin
        bytes_remaining <= '0;
      end else begin
        running_xor     <= running_xor ^ rx_byte;
        bytes_remaining <= bytes_remaining - BYTE_W'(1);
        if (good_len && !pos[0]) begin
          low_byte_hold <= rx_byte;
        end
      end
    end
    if (cmd.emit_load) begin
      out_index <= CIDX_W'(emit_k);
      out_value <= signed'(rdata);
      out_last  <= sts.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_zero_held <= 1'b0;
      phase_one_held  <= 1'b0;
      stage_bank      <= BANK_0;
      p0_bank         <= BANK_1;
      p1_bank         <= BANK_2;
      emit_k          <= '0;
      out_valid       <= 1'b0;
    end else begin
      // a committed packet swaps banks with the staging area, no copy
      if (cmd.commit) begin
        if (packet_phase == PHASE_ZERO) begin
          p0_bank    <= stage_bank;
          stage_bank <= p0_bank;
        end else begin
          p1_bank    <= stage_bank;
          stage_bank <= p1_bank;
        end
      end
      if (cmd.emit_start) begin
        phase_zero_held <= 1'b0;
        phase_one_held  <= 1'b0;
        emit_k          <= '0;
      end else if (cmd.commit) begin
        if (packet_phase == PHASE_ZERO) begin
          phase_zero_held <= 1'b1;
        end else begin
          phase_one_held  <= 1'b1;
        end
      end
      if (cmd.emit_load) begin
        emit_k    <= emit_k + K_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/sfcd_checker.sv
// Port-level checks for the deframer, bound to the top level.
// Depends on sfcd_pkg and sync_framed_channel_deframer_unit.
`timescale 1ns / 1ps

module sfcd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                rx_ready,
  input logic                                ch_valid,
  input logic                                ch_ready,
  input logic [sfcd_pkg::CIDX_W-1:0]         ch_index,
  input logic signed [sfcd_pkg::VALUE_W-1:0] ch_value,
  input logic                                ch_last
);
  import sfcd_pkg::*;

  // only the final channel of a frame carries frame_last
  a_last_matches_index: assert property (@(posedge clk) disable iff (rst)
    ch_valid |-> (ch_last == (ch_index == LAST_CIDX)))
    else $error("frame_last does not match channel index");

  // input is held off while a frame is still being emitted
  a_no_rx_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (ch_valid && !ch_last) |-> !rx_ready)
    else $error("byte input open during frame emission");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !ch_valid)
    else $error("output item present after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (ch_valid && !ch_ready) |=>
      (ch_valid && $stable(ch_index) && $stable(ch_value) && $stable(ch_last)))
    else $error("stalled output item changed");

endmodule

bind sync_framed_channel_deframer_unit sfcd_checker u_sfcd_checker (
  .clk      (clk),
  .rst      (rst),
  .rx_ready (rx.ready),
  .ch_valid (ch.valid),
  .ch_ready (ch.ready),
  .ch_index (ch.channel_index),
  .ch_value (ch.channel_value),
  .ch_last  (ch.frame_last)
);
